/* src/bsui_pkg.sv */
// ----------------------------------------------------------------------------
// bsui_pkg
// Shared types and constants of the bounded set union / intersection core.
// ----------------------------------------------------------------------------
package bsui_pkg;

   localparam int CAPACITY    = 32;
   localparam int DATA_W      = 32;
   localparam int OP_W        = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   localparam logic MODE_UNION     = 1'b0;
   localparam logic MODE_INTERSECT = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD_A,
      KIND_LOAD_B,
      KIND_COMPUTE
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_beat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEXT,
      ST_KEY,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT_RD,
      ST_EMIT_WR,
      ST_EMPTY
   } state_type;

endpackage

/* src/bsui_ram.sv */
// ----------------------------------------------------------------------------
// bsui_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bsui_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/bsui_front.sv */
// ----------------------------------------------------------------------------
// bsui_front
// Accepts request items, classifies the operation and drops unused codes.
// ----------------------------------------------------------------------------
module bsui_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bsui_pkg::DATA_W-1:0]       req_tdata,
   input  logic [bsui_pkg::OP_W-1:0]         req_tuser,
   input  logic                              queue_full,
   output bsui_pkg::cmd_beat_type            push
);
   import bsui_pkg::*;

   logic     known;
   kind_type kind;

   always_comb begin
      known = 1'b1;
      kind  = KIND_LOAD_A;
      case (req_tuser)
         OP_LOAD_A:  kind = KIND_LOAD_A;
         OP_LOAD_B:  kind = KIND_LOAD_B;
         OP_COMPUTE: kind = KIND_COMPUTE;
         default:    known = 1'b0;
      endcase
   end

   assign req_tready     = !queue_full;
   assign push.valid     = req_tvalid && !queue_full && known;
   assign push.cmd.kind  = kind;
   assign push.cmd.value = req_tdata;

endmodule

/* src/bsui_fifo.sv */
// ----------------------------------------------------------------------------
// bsui_fifo
// Short command queue between the front and the back part.
// ----------------------------------------------------------------------------
module bsui_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  bsui_pkg::cmd_beat_type push,
   output logic                   full,
   output bsui_pkg::cmd_beat_type head,
   input  logic                   pop
);
   import bsui_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      do_push   = push.valid && (count_ff != DEPTH_C);
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_C) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_C) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   assign full       = (count_ff == DEPTH_C);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

endmodule

/* src/bsui_back.sv */
// ----------------------------------------------------------------------------
// bsui_back
// Executes queued commands: list loads, result build by element scans, emit.
// ----------------------------------------------------------------------------
module bsui_back #(
   parameter int CAPACITY = bsui_pkg::CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_wdata,
   input  bsui_pkg::cmd_beat_type        head,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bsui_pkg::DATA_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser
);
   import bsui_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_a_ff, count_a_in;
   logic [CNT_W-1:0]  count_b_ff, count_b_in;
   logic              mode_ff, mode_in;
   logic              op_mode_ff, op_mode_in;
   logic              phase_ff, phase_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic              found_ff, found_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  res_n_ff, res_n_in;
   logic [CNT_W-1:0]  emit_ff, emit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_empty_ff, rsp_empty_in;

   logic              a_we, b_we, r_we;
   logic [ADDR_W-1:0] b_raddr, r_raddr;
   logic [DATA_W-1:0] a_rdata, b_rdata, r_rdata, scan_rdata;
   logic [CNT_W-1:0]  limit, emit_next;
   logic              rsp_free, load_rsp, keep;

   bsui_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_list_a (
      .clock (clock),
      .we    (a_we),
      .waddr (count_a_ff[ADDR_W-1:0]),
      .wdata (head.cmd.value),
      .raddr (idx_ff[ADDR_W-1:0]),
      .rdata (a_rdata)
   );

   bsui_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_list_b (
      .clock (clock),
      .we    (b_we),
      .waddr (count_b_ff[ADDR_W-1:0]),
      .wdata (head.cmd.value),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   bsui_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_result (
      .clock (clock),
      .we    (r_we),
      .waddr (res_n_ff[ADDR_W-1:0]),
      .wdata (key_ff),
      .raddr (r_raddr),
      .rdata (r_rdata)
   );

   assign b_raddr = (state_ff == ST_SCAN) ? scan_ff[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
   assign r_raddr = (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_WR) ?
                    emit_ff[ADDR_W-1:0] : scan_ff[ADDR_W-1:0];
   assign scan_rdata = (op_mode_ff == MODE_UNION) ? r_rdata : b_rdata;
   assign limit      = (op_mode_ff == MODE_INTERSECT) ? count_b_ff :
                       (phase_ff ? res_n_ff : '0);
   assign emit_next  = emit_ff + 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign keep       = (op_mode_ff == MODE_UNION) ? !found_ff : found_ff;

   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      mode_in      = csr_we ? csr_wdata : mode_ff;
      op_mode_in   = op_mode_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      found_in     = found_ff;
      key_in       = key_ff;
      res_n_in     = res_n_ff;
      emit_in      = emit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      load_rsp     = 1'b0;
      pop          = 1'b0;
      a_we         = 1'b0;
      b_we         = 1'b0;
      r_we         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.cmd.kind)
                  KIND_LOAD_A: begin
                     if (count_a_ff < CAP_C) begin
                        a_we       = 1'b1;
                        count_a_in = count_a_ff + 1'b1;
                     end
                  end
                  KIND_LOAD_B: begin
                     if (count_b_ff < CAP_C) begin
                        b_we       = 1'b1;
                        count_b_in = count_b_ff + 1'b1;
                     end
                  end
                  KIND_COMPUTE: begin
                     op_mode_in = mode_ff;
                     phase_in   = 1'b0;
                     idx_in     = '0;
                     res_n_in   = '0;
                     state_in   = ST_NEXT;
                  end
                  default: ;
               endcase
            end
         end
         ST_NEXT: begin
            emit_in = '0;
            if (!phase_ff) begin
               if (idx_ff == count_a_ff) begin
                  if (op_mode_ff == MODE_UNION) begin
                     phase_in = 1'b1;
                     idx_in   = '0;
                  end else begin
                     state_in = (res_n_ff == '0) ? ST_EMPTY : ST_EMIT_RD;
                  end
               end else begin
                  state_in = ST_KEY;
               end
            end else begin
               if (idx_ff == count_b_ff || res_n_ff == CAP_C) begin
                  state_in = (res_n_ff == '0) ? ST_EMPTY : ST_EMIT_RD;
               end else begin
                  state_in = ST_KEY;
               end
            end
         end
         ST_KEY: begin
            key_in   = phase_ff ? b_rdata : a_rdata;
            idx_in   = idx_ff + 1'b1;
            scan_in  = '0;
            pend_in  = 1'b0;
            found_in = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (pend_ff && scan_rdata == key_ff) begin
               found_in = 1'b1;
            end
            if (scan_ff < limit && !found_ff) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (found_ff || (scan_ff == limit && !pend_ff)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (keep) begin
               r_we     = 1'b1;
               res_n_in = res_n_ff + 1'b1;
            end
            state_in = ST_NEXT;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (rsp_free) begin
               load_rsp     = 1'b1;
               rsp_data_in  = r_rdata;
               rsp_last_in  = (emit_next == res_n_ff);
               rsp_empty_in = 1'b0;
               emit_in      = emit_next;
               if (emit_next == res_n_ff) begin
                  count_a_in = '0;
                  count_b_in = '0;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_EMPTY: begin
            if (rsp_free) begin
               load_rsp     = 1'b1;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
               count_a_in   = '0;
               count_b_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         mode_ff      <= MODE_UNION;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_mode_ff   <= op_mode_in;
      phase_ff     <= phase_in;
      idx_ff       <= idx_in;
      scan_ff      <= scan_in;
      pend_ff      <= pend_in;
      found_ff     <= found_in;
      key_ff       <= key_in;
      res_n_ff     <= res_n_in;
      emit_ff      <= emit_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;

`ifndef NO_ASSERTIONS
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      count_a_ff <= CAP_C && count_b_ff <= CAP_C)
      else $error("list count above capacity");

   a_result_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> res_n_ff <= CAP_C)
      else $error("result count above capacity");

   a_empty_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_last_ff && rsp_data_ff == '0))
      else $error("empty item not last or not zero");

   a_a_phase_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && op_mode_ff == MODE_UNION && !phase_ff) |-> !found_ff)
      else $error("union dropped an element of list a");
`endif

endmodule

/* src/bounded_set_union_intersection_core.sv */
// ----------------------------------------------------------------------------
// bounded_set_union_intersection_core
// Loads two bounded lists and emits their union or intersection on demand.
// ----------------------------------------------------------------------------
// req channel: tuser carries the operation (load a, load b, compute), tdata
//   the element; unused operation codes are taken and dropped
// rsp channel: one item per result element, tlast on the final one, tuser
//   set on the single zero item that reports an empty result
// csr_we / csr_wdata write the mode bit (0 union, 1 intersection)
// items pass a four entry queue into the execution part, so the request side
//   keeps taking items while a result waits on a stalled receiver, until the queue is full
// a load is written into its list ram in the same cycle as it leaves the queue
// a compute takes each element of list a (in union mode then list b), scans it
//   against list b (intersection) or the result so far (union; list a elements
//   are kept without a scan), keeps or drops it, then emits the result items
//   one by one; the single read port of each list ram paces these steps
// a stalled receiver holds the output register and the compute pauses there
// reset empties both lists and the queue, sets union mode, no clearing pass
// ----------------------------------------------------------------------------
module bounded_set_union_intersection_core #(
   parameter int CAPACITY = bsui_pkg::CAPACITY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [bsui_pkg::DATA_W-1:0] req_tdata,   // value
   input  logic [bsui_pkg::OP_W-1:0]   req_tuser,   // operation
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [bsui_pkg::DATA_W-1:0] rsp_tdata,   // value_res
   output logic                        rsp_tlast,
   output logic                        rsp_tuser,   // empty_res
   input  logic                        csr_we,
   input  logic                        csr_wdata
);
   import bsui_pkg::*;

   cmd_beat_type push;
   cmd_beat_type head;
   logic         queue_full;
   logic         pop;

   bsui_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push)
   );

   bsui_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   bsui_back #(.CAPACITY(CAPACITY)) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* tb/sv/bsui_set_checker.sv */
// ----------------------------------------------------------------------------
// bsui_set_checker
// Watches the request, result and csr ports of the set core, keeps its own
// copy of both lists and the mode, and builds the union or intersection on
// every accepted compute. Each accepted result item is compared field by
// field with the oldest predicted one; the failure count and the number of
// outstanding predictions go back to the testbench top.
// ----------------------------------------------------------------------------
module bsui_set_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [bsui_pkg::DATA_W-1:0] req_tdata,
   input  logic [bsui_pkg::OP_W-1:0]   req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [bsui_pkg::DATA_W-1:0] rsp_tdata,
   input  logic                        rsp_tlast,
   input  logic                        rsp_tuser,
   input  logic                        csr_we,
   input  logic                        csr_wdata,
   output int                          error_count,
   output int                          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bsui_pkg::*;

   typedef struct {
      logic [DATA_W-1:0] value;
      logic              last;
      logic              empty_flag;
   } set_item_type;

   logic              set_mode;
   logic [DATA_W-1:0] list_a [$];
   logic [DATA_W-1:0] list_b [$];
   set_item_type      result_items [$];
   int                fail_total;

   function automatic bit holds_value(input logic [DATA_W-1:0] list [$],
                                      input logic [DATA_W-1:0] v);
      foreach (list[i]) begin
         if (list[i] == v) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic build_result();
      logic [DATA_W-1:0] merged [$];
      if (set_mode == MODE_UNION) begin
         merged = list_a;
         foreach (list_b[i]) begin
            if (merged.size() < CAPACITY && !holds_value(merged, list_b[i])) begin
               merged.push_back(list_b[i]);
            end
         end
      end else begin
         foreach (list_a[i]) begin
            if (holds_value(list_b, list_a[i])) begin
               merged.push_back(list_a[i]);
            end
         end
      end
      if (merged.size() == 0) begin
         result_items.push_back('{value: '0, last: 1'b1, empty_flag: 1'b1});
      end else begin
         foreach (merged[k]) begin
            result_items.push_back('{value: merged[k],
                                     last: (k == merged.size() - 1),
                                     empty_flag: 1'b0});
         end
      end
      list_a.delete();
      list_b.delete();
   endtask

   always @(posedge clock) begin
      set_item_type want;
      if (reset) begin
         set_mode = MODE_UNION;
         list_a.delete();
         list_b.delete();
         result_items.delete();
         fail_total = 0;
      end else begin
         if (csr_we) begin
            set_mode = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_LOAD_A: begin
                  if (list_a.size() < CAPACITY) begin
                     list_a.push_back(req_tdata);
                  end
               end
               OP_LOAD_B: begin
                  if (list_b.size() < CAPACITY) begin
                     list_b.push_back(req_tdata);
                  end
               end
               OP_COMPUTE: begin
                  build_result();
               end
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (result_items.size() == 0) begin
               $error("result item with none predicted: value_res %h", rsp_tdata);
               fail_total++;
            end else begin
               want = result_items.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("value_res: expected %h, got %h", want.value, rsp_tdata);
                  fail_total++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_tlast);
                  fail_total++;
               end
               if (rsp_tuser !== want.empty_flag) begin
                  $error("empty_res: expected %b, got %b", want.empty_flag, rsp_tuser);
                  fail_total++;
               end
            end
         end
      end
      error_count   <= fail_total;
      pending_count <= result_items.size();
   end

endmodule

/* tb/sv/tb_bounded_set_union_intersection_core.sv */
// ----------------------------------------------------------------------------
// tb_bounded_set_union_intersection_core
// Drives the set core with a short directed run through both modes, then
// random list pairs with duplicates, one-sided and empty computes, full lists,
// union overflow and unused operation codes, under changing idle patterns and
// one long receiver stall. The checker beside the core does the comparing.
// ----------------------------------------------------------------------------
module tb_bounded_set_union_intersection_core;
   timeunit 1ns;
   timeprecision 1ps;
   import bsui_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int SETTLE_CYCLES   = 64;
   localparam int PHASE_ITEMS     = 8;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;   // value
   logic [OP_W-1:0]   req_tuser;   // operation
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;   // value_res
   logic              rsp_tlast;
   logic              rsp_tuser;   // empty_res
   logic              csr_we;
   logic              csr_wdata;

   int error_count;
   int pending_count;
   int send_idle_pct;
   int recv_idle_pct;
   int sent_items;
   bit hold_off_request;

   always #5 clock = ~clock;

   bounded_set_union_intersection_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   bsui_set_checker u_set_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (op != OP_UNUSED) begin
         sent_items++;
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // loads in random order from a small pool so duplicates and matches occur
   task automatic run_set_pair(input int na, input int nb, input int reuse_pct);
      logic [DATA_W-1:0] pool [4];
      logic [DATA_W-1:0] v;
      int left_a;
      int left_b;
      foreach (pool[i]) pool[i] = $urandom();
      left_a = na;
      left_b = nb;
      while (left_a + left_b > 0) begin
         if ($urandom_range(0, 99) < 5) begin
            send_item(OP_UNUSED, $urandom());
         end
         v = ($urandom_range(0, 99) < reuse_pct) ? pool[$urandom_range(0, 3)] : $urandom();
         if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 0)) begin
            send_item(OP_LOAD_A, v);
            left_a--;
         end else begin
            send_item(OP_LOAD_B, v);
            left_b--;
         end
      end
      send_item(OP_COMPUTE, $urandom());
   endtask

   task automatic run_random_phase(input int budget);
      int start;
      start = sent_items;
      while (sent_items - start < budget) begin
         case ($urandom_range(0, 9))
            0: send_item(OP_COMPUTE, $urandom());
            1: run_set_pair($urandom_range(1, 4), 0, 75);
            2: run_set_pair(0, $urandom_range(1, 4), 75);
            default: run_set_pair($urandom_range(1, 8), $urandom_range(1, 8), 75);
         endcase
      end
   endtask

   initial begin : receiver
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      send_idle_pct    = 22;
      recv_idle_pct    = 79;
      sent_items       = 0;
      hold_off_request = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_LOAD_A;
      csr_we     <= 1'b0;
      csr_wdata  <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // union: extremes, duplicates in b, b values already in a
      write_mode(MODE_UNION);
      send_item(OP_LOAD_A, 32'h8000_0000);
      send_item(OP_LOAD_A, 32'h7FFF_FFFF);
      send_item(OP_LOAD_B, 32'hFFFF_FFFF);
      send_item(OP_LOAD_A, 32'h0000_0000);
      send_item(OP_UNUSED, 32'hDEAD_BEEF);
      send_item(OP_LOAD_A, 32'hFFFF_FFFF);
      send_item(OP_LOAD_B, 32'h0000_0005);
      send_item(OP_LOAD_B, 32'h7FFF_FFFF);
      send_item(OP_LOAD_B, 32'h0000_0005);
      send_item(OP_COMPUTE, 32'hFFFF_FFFF);
      send_item(OP_COMPUTE, 32'h0000_0000);
      wait_idle();

      // intersection: repeated a elements, no match, b only
      write_mode(MODE_INTERSECT);
      send_item(OP_LOAD_A, 32'd7);
      send_item(OP_LOAD_A, 32'd7);
      send_item(OP_LOAD_B, 32'd7);
      send_item(OP_LOAD_A, 32'd3);
      send_item(OP_LOAD_A, 32'd8);
      send_item(OP_LOAD_B, 32'd3);
      send_item(OP_COMPUTE, 32'd0);
      send_item(OP_LOAD_A, 32'd1);
      send_item(OP_LOAD_B, 32'd2);
      send_item(OP_COMPUTE, 32'd0);
      send_item(OP_LOAD_B, 32'd9);
      send_item(OP_COMPUTE, 32'd0);
      wait_idle();

      run_random_phase(PHASE_ITEMS);
      wait_idle();

      send_idle_pct = 79;
      recv_idle_pct = 22;
      write_mode(MODE_UNION);
      run_random_phase(PHASE_ITEMS);
      wait_idle();

      // full lists and union overflow, with the receiver held off meanwhile
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_request = 1'b1;
      run_set_pair(CAPACITY + 1, 2, 0);
      run_set_pair(4, CAPACITY + 1, 0);
      wait_idle();

      write_mode(MODE_INTERSECT);
      run_random_phase(PHASE_ITEMS / 2);
      wait_idle();

      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
